>>> rtl/core/pss_pkg.sv
// types and constants shared by the plucked-string synthesiser
package pss_pkg;

    localparam int SAMPLE_W = 24;
    localparam int SEED_W   = 20;
    localparam int GAIN_W   = 16;
    localparam int PERIOD_W = 9;
    localparam int CFG_IDX_W = 2;

    // shared multiplier: signed 25 x 17 covers the seed, the delayed sample and the difference
    localparam int MUL_A_W = SAMPLE_W + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = PROD_W - 15;
    localparam int ACC_W   = TERM_W + 1;

    localparam int STEP_W      = 4;
    localparam int NOISE_DRAWS = 12;

    localparam logic signed [MUL_B_W-1:0] LCG_MULT   = 17'sd2045;
    localparam logic        [SEED_W-1:0]  SEED_RESET = 20'd13579;
    localparam logic signed [PROD_W-1:0]  ROUND_BIAS = 42'sd16384;
    // 6.0 in Q8.16
    localparam logic signed [SAMPLE_W-1:0] NOISE_OFFSET = 24'sd393216;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 28'sd8388607;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -28'sd8388608;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RESET    = 16'd29491;
    localparam logic [GAIN_W-1:0] TILT_GAIN_RESET        = 16'd3277;
    localparam logic [GAIN_W-1:0] NOISE_LAST_INDEX_RESET = 16'd3000;
    localparam logic [GAIN_W-1:0] COUNT_MAX              = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_GAIN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LAST_INDEX = 2'd2;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NOISE,
        ST_FEEDBACK,
        ST_TILT,
        ST_WRITE
    } pss_state_t;

endpackage

>>> rtl/core/plucked_string_synth.sv
// plucked-string synthesiser: noise burst into a damped circular delay loop
//
// One input word gives one output sample. After acceptance a word passes
// through twelve noise-generator steps, the feedback product, the tilt
// product and a step that saturates and writes back, which holds while the
// output register is full; all multiplies use a single shared 25 x 17
// multiplier. in_ready is low while a word is in work. The output register
// lets a new word be taken while the last sample waits; a finished sample
// waits there until out_ready. After reset the delay store is cleared one
// entry a cycle, so in_ready stays low until every entry is cleared.
module plucked_string_synth #(
    parameter int DELAY_DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pss_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pss_pkg::GAIN_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic [pss_pkg::PERIOD_W-1:0]          note_period,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pss_pkg::SAMPLE_W-1:0]   sample
);

    localparam int IDX_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int LEN_W = $clog2(DELAY_DEPTH + 1);
    localparam int CMP_W = (LEN_W > pss_pkg::PERIOD_W) ? LEN_W : pss_pkg::PERIOD_W;
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DELAY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DELAY_DEPTH - 1);

    pss_pkg::pss_state_t state_reg, state_next;

    logic [pss_pkg::GAIN_W-1:0] fb_gain_reg, fb_gain_next;
    logic [pss_pkg::GAIN_W-1:0] tilt_gain_reg, tilt_gain_next;
    logic [pss_pkg::GAIN_W-1:0] noise_last_reg, noise_last_next;

    logic [IDX_W-1:0]               clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]               read_index_reg, read_index_next;
    logic [LEN_W-1:0]               loop_len_reg, loop_len_next;
    logic [pss_pkg::GAIN_W-1:0]     count_reg, count_next;
    logic [pss_pkg::SEED_W-1:0]     seed_reg, seed_next;
    logic signed [pss_pkg::SAMPLE_W-1:0] prev_out_reg, prev_out_next;
    logic signed [pss_pkg::SAMPLE_W-1:0] prev_noise_reg, prev_noise_next;
    logic [pss_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;

    logic [pss_pkg::SAMPLE_W-1:0]        sum_reg, sum_next;
    logic signed [pss_pkg::TERM_W-1:0]   fb_term_reg, fb_term_next;
    logic signed [pss_pkg::TERM_W-1:0]   tilt_term_reg, tilt_term_next;
    logic signed [pss_pkg::SAMPLE_W-1:0] sample_reg, sample_next;

    logic signed [pss_pkg::SAMPLE_W-1:0] delay_mem [DELAY_DEPTH];
    logic signed [pss_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                                mem_we;
    logic [IDX_W-1:0]                    mem_addr;
    logic signed [pss_pkg::SAMPLE_W-1:0] mem_wdata;

    logic signed [pss_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pss_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pss_pkg::PROD_W-1:0]  mul_p;
    logic signed [pss_pkg::PROD_W-1:0]  mul_round;
    logic signed [pss_pkg::TERM_W-1:0]  mul_term;
    logic [pss_pkg::SEED_W-1:0]         lcg_next;

    logic [CMP_W-1:0]                    period_ext;
    logic [CMP_W-1:0]                    period_clamped;
    logic [LEN_W-1:0]                    idx_inc;
    logic signed [pss_pkg::SAMPLE_W-1:0] noise_raw;
    logic signed [pss_pkg::SAMPLE_W-1:0] noise_gated;
    logic signed [pss_pkg::ACC_W-1:0]    acc;
    logic signed [pss_pkg::SAMPLE_W-1:0] y_sat;
    logic                                commit;

    assign mul_p     = mul_a * mul_b;
    assign mul_round = mul_p + pss_pkg::ROUND_BIAS;
    // top bits of the biased product: floor shift by 15
    assign mul_term  = mul_round[pss_pkg::PROD_W-1:15];
    assign lcg_next  = mul_p[pss_pkg::SEED_W-1:0] + pss_pkg::SEED_W'(1);

    assign period_ext = CMP_W'(note_period);
    always_comb
    begin
        if (period_ext == '0)
            period_clamped = CMP_W'(1);
        else if (period_ext > DEPTH_CMP)
            period_clamped = DEPTH_CMP;
        else
            period_clamped = period_ext;
    end

    assign idx_inc = LEN_W'(read_index_reg) + LEN_W'(1);

    assign noise_raw   = $signed({4'b0000, sum_reg[pss_pkg::SAMPLE_W-1:4]}) - pss_pkg::NOISE_OFFSET;
    assign noise_gated = (count_reg > noise_last_reg) ? '0 : noise_raw;

    assign acc = {{(pss_pkg::ACC_W - pss_pkg::SAMPLE_W){noise_gated[pss_pkg::SAMPLE_W-1]}},
                  noise_gated}
               + {fb_term_reg[pss_pkg::TERM_W-1], fb_term_reg}
               + {tilt_term_reg[pss_pkg::TERM_W-1], tilt_term_reg};

    always_comb
    begin
        if (acc > pss_pkg::ACC_MAX)
            y_sat = pss_pkg::SAMPLE_MAX;
        else if (acc < pss_pkg::ACC_MIN)
            y_sat = pss_pkg::SAMPLE_MIN;
        else
            y_sat = acc[pss_pkg::SAMPLE_W-1:0];
    end

    assign in_ready  = (state_reg == pss_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (state_reg)
            pss_pkg::ST_NOISE:
            begin
                mul_a = $signed({5'b00000, seed_reg});
                mul_b = pss_pkg::LCG_MULT;
            end
            pss_pkg::ST_FEEDBACK:
            begin
                mul_a = {rd_data_reg[pss_pkg::SAMPLE_W-1], rd_data_reg};
                mul_b = $signed({1'b0, fb_gain_reg});
            end
            pss_pkg::ST_TILT:
            begin
                mul_a = {prev_out_reg[pss_pkg::SAMPLE_W-1], prev_out_reg}
                      - {prev_noise_reg[pss_pkg::SAMPLE_W-1], prev_noise_reg};
                mul_b = $signed({1'b0, tilt_gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        fb_gain_next    = fb_gain_reg;
        tilt_gain_next  = tilt_gain_reg;
        noise_last_next = noise_last_reg;
        clr_idx_next    = clr_idx_reg;
        read_index_next = read_index_reg;
        loop_len_next   = loop_len_reg;
        count_next      = count_reg;
        seed_next       = seed_reg;
        prev_out_next   = prev_out_reg;
        prev_noise_next = prev_noise_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sum_next        = sum_reg;
        fb_term_next    = fb_term_reg;
        tilt_term_next  = tilt_term_reg;
        sample_next     = sample_reg;
        mem_we          = 1'b0;
        mem_addr        = read_index_reg;
        mem_wdata       = y_sat;
        commit          = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                pss_pkg::CFG_FEEDBACK_GAIN:    fb_gain_next    = cfg_data;
                pss_pkg::CFG_TILT_GAIN:        tilt_gain_next  = cfg_data;
                pss_pkg::CFG_NOISE_LAST_INDEX: noise_last_next = cfg_data;
                default:                       ;
            endcase
        end

        case (state_reg)
            pss_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX)
                    state_next = pss_pkg::ST_IDLE;
            end
            pss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sum_next  = '0;
                    step_next = '0;
                    if (operation == pss_pkg::OP_START)
                    begin
                        loop_len_next   = period_clamped[LEN_W-1:0];
                        read_index_next = '0;
                        count_next      = '0;
                        prev_out_next   = '0;
                        prev_noise_next = '0;
                    end
                    state_next = pss_pkg::ST_NOISE;
                end
            end
            pss_pkg::ST_NOISE:
            begin
                seed_next = lcg_next;
                sum_next  = sum_reg + pss_pkg::SAMPLE_W'(lcg_next);
                step_next = step_reg + pss_pkg::STEP_W'(1);
                if (step_reg == pss_pkg::STEP_W'(pss_pkg::NOISE_DRAWS - 1))
                    state_next = pss_pkg::ST_FEEDBACK;
            end
            pss_pkg::ST_FEEDBACK:
            begin
                fb_term_next = mul_term;
                state_next   = pss_pkg::ST_TILT;
            end
            pss_pkg::ST_TILT:
            begin
                tilt_term_next = mul_term;
                state_next     = pss_pkg::ST_WRITE;
            end
            pss_pkg::ST_WRITE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    commit          = 1'b1;
                    mem_we          = 1'b1;
                    sample_next     = y_sat;
                    out_valid_next  = 1'b1;
                    prev_out_next   = y_sat;
                    prev_noise_next = noise_gated;
                    if (count_reg != pss_pkg::COUNT_MAX)
                        count_next = count_reg + pss_pkg::GAIN_W'(1);
                    if (idx_inc >= loop_len_reg)
                        read_index_next = '0;
                    else
                        read_index_next = idx_inc[IDX_W-1:0];
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pss_pkg::ST_CLEAR;
            fb_gain_reg    <= pss_pkg::FEEDBACK_GAIN_RESET;
            tilt_gain_reg  <= pss_pkg::TILT_GAIN_RESET;
            noise_last_reg <= pss_pkg::NOISE_LAST_INDEX_RESET;
            clr_idx_reg    <= '0;
            read_index_reg <= '0;
            loop_len_reg   <= LEN_W'(1);
            count_reg      <= '0;
            seed_reg       <= pss_pkg::SEED_RESET;
            prev_out_reg   <= '0;
            prev_noise_reg <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fb_gain_reg    <= fb_gain_next;
            tilt_gain_reg  <= tilt_gain_next;
            noise_last_reg <= noise_last_next;
            clr_idx_reg    <= clr_idx_next;
            read_index_reg <= read_index_next;
            loop_len_reg   <= loop_len_next;
            count_reg      <= count_next;
            seed_reg       <= seed_next;
            prev_out_reg   <= prev_out_next;
            prev_noise_reg <= prev_noise_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        fb_term_reg   <= fb_term_next;
        tilt_term_reg <= tilt_term_next;
        if (commit)
            sample_reg <= sample_next;
    end

    // delay store: one write port, registered read at the loop position
    always_ff @(posedge clk)
    begin
        if (mem_we)
            delay_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= delay_mem[read_index_reg];
    end

endmodule

>>> rtl/core/pss_checker.sv
// port-level checks for the plucked-string synthesiser, bound to the top level
module pss_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [pss_pkg::SAMPLE_W-1:0] sample
);

    // no second word while one is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a word was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##15 !in_ready)
    else $error("in_ready back before the sample was written");

    // a sample newly offered with no stall must trace back to a word that was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 16))
    else $error("sample offered without a word taken sixteen cycles before");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample))
    else $error("stalled sample dropped or changed");

endmodule

bind plucked_string_synth pss_checker u_pss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
);

>>> verif/plucked_string_checker.sv
// watches the plucked-string synthesiser channels, predicts each sample and compares
module plucked_string_checker #(
    parameter int DELAY_DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pss_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pss_pkg::GAIN_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  operation,
    input  logic [pss_pkg::PERIOD_W-1:0]          note_period,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [pss_pkg::SAMPLE_W-1:0]   sample,
    output int                                    mismatch_count,
    output int                                    pending
);

    logic signed [pss_pkg::SAMPLE_W-1:0] string_loop [DELAY_DEPTH];
    int                                  tap;
    int                                  loop_len;
    int unsigned                         note_count;
    logic [pss_pkg::SEED_W-1:0]          seed;
    int                                  last_out;
    int                                  last_noise;
    logic [pss_pkg::GAIN_W-1:0]          feedback_gain;
    logic [pss_pkg::GAIN_W-1:0]          tilt_gain;
    logic [pss_pkg::GAIN_W-1:0]          noise_last;

    logic signed [pss_pkg::SAMPLE_W-1:0] expected_samples [$];
    logic signed [pss_pkg::SAMPLE_W-1:0] want;
    int                                  errors;

    // q8.16 times q1.15, round half up then floor back to q8.16
    function automatic longint scale_q15(
        input longint                     x,
        input logic [pss_pkg::GAIN_W-1:0] g
    );
        return (x * longint'(g) + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [pss_pkg::SAMPLE_W-1:0] next_string_sample(
        input logic                         op,
        input logic [pss_pkg::PERIOD_W-1:0] period
    );
        int                                  p;
        logic [31:0]                         draw_sum;
        logic [31:0]                         lcg;
        int                                  noise;
        longint                              acc;
        logic signed [pss_pkg::SAMPLE_W-1:0] y;
        if (op == pss_pkg::OP_START)
        begin
            p = int'(period);
            if (p == 0)
                p = 1;
            if (p > DELAY_DEPTH)
                p = DELAY_DEPTH;
            loop_len   = p;
            tap        = 0;
            note_count = 0;
            last_out   = 0;
            last_noise = 0;
        end
        draw_sum = '0;
        for (int i = 0; i < pss_pkg::NOISE_DRAWS; i++)
        begin
            lcg      = 32'd2045 * 32'(seed) + 32'd1;
            seed     = lcg[pss_pkg::SEED_W-1:0];
            draw_sum = draw_sum + 32'(seed);
        end
        // sum of q0.20 draws down to q8.16, then minus 6.0
        noise = int'(draw_sum >> 4) - (6 << 16);
        // seed still advances after the burst, only the noise is muted
        if (note_count > noise_last)
            noise = 0;
        if (note_count < 32'hFFFF)
            note_count++;
        acc = longint'(noise)
            + scale_q15(longint'(string_loop[tap]), feedback_gain)
            + scale_q15(longint'(last_out) - longint'(last_noise), tilt_gain);
        if (acc > 64'sd8388607)
            y = pss_pkg::SAMPLE_MAX;
        else if (acc < -64'sd8388608)
            y = pss_pkg::SAMPLE_MIN;
        else
            y = acc[pss_pkg::SAMPLE_W-1:0];
        string_loop[tap] = y;
        last_out   = int'(y);
        last_noise = noise;
        tap++;
        if (tap >= loop_len)
            tap = 0;
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DELAY_DEPTH; i++)
                string_loop[i] = '0;
            tap           = 0;
            loop_len      = 1;
            note_count    = 0;
            seed          = pss_pkg::SEED_RESET;
            last_out      = 0;
            last_noise    = 0;
            feedback_gain = pss_pkg::FEEDBACK_GAIN_RESET;
            tilt_gain     = pss_pkg::TILT_GAIN_RESET;
            noise_last    = pss_pkg::NOISE_LAST_INDEX_RESET;
            expected_samples.delete();
            errors = 0;
            mismatch_count <= 0;
            pending        <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected sample word %0d, nothing outstanding", sample);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want)
                    begin
                        if (errors < 10)
                            $display("sample mismatch: expected %0d, got %0d", want, sample);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    pss_pkg::CFG_FEEDBACK_GAIN:    feedback_gain = cfg_data;
                    pss_pkg::CFG_TILT_GAIN:        tilt_gain     = cfg_data;
                    pss_pkg::CFG_NOISE_LAST_INDEX: noise_last    = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_samples.push_back(next_string_sample(operation, note_period));
            mismatch_count <= errors;
            pending        <= expected_samples.size();
        end
    end

endmodule

>>> verif/plucked_string_synth_tb.sv
// stimulus and verdict for the plucked-string synthesiser
module plucked_string_synth_tb;

    localparam int DEPTH = 256;
    // index with no register behind it, writes must be dropped
    localparam logic [pss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b1;
    logic                                cfg_we = 1'b0;
    logic [pss_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [pss_pkg::GAIN_W-1:0]          cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                operation = pss_pkg::OP_STEP;
    logic [pss_pkg::PERIOD_W-1:0]        note_period = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [pss_pkg::SAMPLE_W-1:0] sample;
    int                                  mismatch_count;
    int                                  pending;

    int                          items_sent = 0;
    int                          gap_pct = 30;
    bit                          calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    plucked_string_synth #(
        .DELAY_DEPTH (DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .note_period (note_period),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample)
    );

    plucked_string_checker #(
        .DELAY_DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .note_period    (note_period),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    task automatic send_word(input logic op, input logic [pss_pkg::PERIOD_W-1:0] period);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        note_period <= period;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(
        input logic [pss_pkg::CFG_IDX_W-1:0] idx,
        input logic [pss_pkg::GAIN_W-1:0]    value
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and wait for every outstanding sample to drain
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [pss_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            3:       return pss_pkg::GAIN_W'($urandom);
            default: return pss_pkg::GAIN_W'($urandom_range(26000, 32768));
        endcase
    endfunction

    function automatic logic [pss_pkg::GAIN_W-1:0] pick_burst();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd3000;
            default: return pss_pkg::GAIN_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [pss_pkg::PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return pss_pkg::PERIOD_W'($urandom_range(257, 511));
            2:       return pss_pkg::PERIOD_W'($urandom_range(1, 256));
            default: return pss_pkg::PERIOD_W'($urandom_range(1, 24));
        endcase
    endfunction

    // receiver: ready stretches, some long, broken by short stalls
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (calm || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(50, 200)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int notes;
        int len;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // delay store clearing pass after reset
        do
            @(posedge clk);
        while (!in_ready);

        // steps before any note, then out-of-range periods
        send_word(pss_pkg::OP_STEP, 9'h1FF);
        send_word(pss_pkg::OP_STEP, 9'h000);
        send_word(pss_pkg::OP_START, 9'd0);
        send_word(pss_pkg::OP_STEP, 9'd0);
        send_word(pss_pkg::OP_STEP, 9'h1FF);
        send_word(pss_pkg::OP_START, 9'h1FF);
        send_word(pss_pkg::OP_STEP, 9'd5);
        send_word(pss_pkg::OP_STEP, 9'd6);

        settle();
        write_reg(pss_pkg::CFG_FEEDBACK_GAIN, 16'hFFFF);
        write_reg(pss_pkg::CFG_TILT_GAIN, 16'hFFFF);
        write_reg(pss_pkg::CFG_NOISE_LAST_INDEX, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_word(pss_pkg::OP_START, 9'd3);
        repeat (5) send_word(pss_pkg::OP_STEP, pss_pkg::PERIOD_W'($urandom));

        settle();
        write_reg(pss_pkg::CFG_FEEDBACK_GAIN, 16'd0);
        write_reg(pss_pkg::CFG_TILT_GAIN, 16'd0);
        write_reg(pss_pkg::CFG_NOISE_LAST_INDEX, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'd0);
        send_word(pss_pkg::OP_START, 9'd256);
        send_word(pss_pkg::OP_STEP, 9'd0);
        send_word(pss_pkg::OP_START, 9'd1);
        send_word(pss_pkg::OP_STEP, 9'd0);

        settle();
        write_reg(pss_pkg::CFG_FEEDBACK_GAIN, 16'd32768);
        write_reg(pss_pkg::CFG_TILT_GAIN, 16'd32768);
        write_reg(pss_pkg::CFG_NOISE_LAST_INDEX, 16'd2);
        send_word(pss_pkg::OP_START, 9'd257);
        repeat (4) send_word(pss_pkg::OP_STEP, pss_pkg::PERIOD_W'($urandom));

        // random notes: a start, then a run of steps, now and then no start
        while (items_sent < 370)
        begin
            settle();
            if (items_sent >= 310)
                calm = 1'b1;
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 20;
                default: gap_pct = 50;
            endcase
            if ($urandom_range(0, 2) != 0)
                write_reg(pss_pkg::CFG_FEEDBACK_GAIN, pick_gain());
            if ($urandom_range(0, 2) != 0)
                write_reg(pss_pkg::CFG_TILT_GAIN, pick_gain());
            if ($urandom_range(0, 2) != 0)
                write_reg(pss_pkg::CFG_NOISE_LAST_INDEX, pick_burst());
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_UNUSED, pss_pkg::GAIN_W'($urandom));
            notes = $urandom_range(1, 4);
            repeat (notes)
            begin
                if ($urandom_range(0, 7) != 0)
                    send_word(pss_pkg::OP_START, pick_period());
                len = $urandom_range(0, 50);
                repeat (len) send_word(pss_pkg::OP_STEP, pss_pkg::PERIOD_W'($urandom));
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
